// ----- rtl/core/ialu_pkg.sv -----
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants for the shader integer ALU
// Operation, type and error codes, pipeline context and type fitting.
// ----------------------------------------------------------------------------
package ialu_pkg;

	localparam int unsigned DataW = 64;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_REM = 4'd4;
	localparam logic [3:0] OP_AND = 4'd5;
	localparam logic [3:0] OP_OR  = 4'd6;
	localparam logic [3:0] OP_XOR = 4'd7;
	localparam logic [3:0] OP_SHL = 4'd8;
	localparam logic [3:0] OP_SHR = 4'd9;
	localparam logic [3:0] OP_EQ  = 4'd10;
	localparam logic [3:0] OP_NE  = 4'd11;
	localparam logic [3:0] OP_LT  = 4'd12;
	localparam logic [3:0] OP_LE  = 4'd13;
	localparam logic [3:0] OP_GT  = 4'd14;
	localparam logic [3:0] OP_GE  = 4'd15;

	localparam logic [1:0] TY_I32 = 2'd0;
	localparam logic [1:0] TY_U32 = 2'd1;
	localparam logic [1:0] TY_ABS = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_DIV_OVF  = 3'd1;
	localparam logic [2:0] ERR_SHAMT    = 3'd2;
	localparam logic [2:0] ERR_SHL_OVF  = 3'd3;
	localparam logic [2:0] ERR_DIV_ZERO = 3'd4;

	localparam logic [63:0] I32_MIN_SX = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] I64_MIN    = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic        div_use;
		logic        quot;
		logic        q_neg;
		logic        r_neg;
		logic        is_mul;
		logic        is_bool;
		logic [1:0]  tt;
		logic [2:0]  err;
		logic [63:0] res;
	} ctx_t;

	function automatic logic [63:0] fit_type(input logic [63:0] v, input logic [1:0] tt);
		logic [63:0] r;
		case (tt)
			TY_I32:  r = {{32{v[31]}}, v[31:0]};
			TY_U32:  r = {32'd0, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/ialu_if.sv -----
// ----------------------------------------------------------------------------
// ialu_if: channel interfaces of the integer ALU
// Request, response and mode-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ialu_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [1:0]  type_sel;
	logic signed [63:0] operand_a;
	logic signed [63:0] operand_b;
	modport source (output valid, action, type_sel, operand_a, operand_b, input ready);
	modport sink (input valid, action, type_sel, operand_a, operand_b, output ready);
endinterface

interface ialu_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [63:0] result_value;
	logic        is_boolean;
	logic [2:0]  error_code;
	modport source (output valid, result_value, is_boolean, error_code, input ready);
	modport sink (input valid, result_value, is_boolean, error_code, output ready);
endinterface

interface ialu_cfg_if;
	logic valid;
	logic ready;
	logic runtime_mode;
	modport source (output valid, runtime_mode, input ready);
	modport sink (input valid, runtime_mode, output ready);
endinterface

// ----- rtl/core/shader_integer_alu.sv -----
// ----------------------------------------------------------------------------
// shader_integer_alu: pipelined typed integer ALU
// Sixteen operations on i32, u32 and 64-bit abstract ints, one per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------
//  req     | in  | action, type_sel, operand_a, operand_b
//  rsp     | out | result_value, is_boolean, error_code
//  cfg     | in  | runtime_mode (always ready)
//
// One beat enters per cycle while the pipeline advances; every beat passes 68
// register stages, the last of them the output register. The depth is set by
// the 64-step radix-2 divider chain that all operations travel through so
// results leave in order.
// The pipeline advances as a whole whenever the output register is empty or
// being taken; a stall holds every stage, so nothing is lost or repeated.
// Reset clears the valid bits and runtime_mode only.
// ----------------------------------------------------------------------------
module shader_integer_alu (
	input logic        clk,
	input logic        arst_n,
	ialu_req_if.sink   req,
	ialu_rsp_if.source rsp,
	ialu_cfg_if.sink   cfg
);

	localparam int unsigned Steps = ialu_pkg::DataW;

	logic mode_q;
	logic adv;

	// stage 1: captured request
	logic        valid_s1;
	logic [3:0]  action_s1;
	logic [1:0]  type_s1;
	logic [63:0] opa_s1, opb_s1;
	logic        mode_s1;

	// stage 2: executed, multiply partials pending
	ialu_pkg::ctx_t ctx_x, ctx_s2, ctx_s3, ctx_m;
	logic        valid_s2, valid_s3;
	logic [63:0] pp_ll_x, pp_ll_s2;
	logic [31:0] pp_lh_x, pp_lh_s2, pp_hl_x, pp_hl_s2;
	logic [63:0] dn_x, dn_s2, dd_x, dd_s2;

	// stage 3: divider entry
	logic [63:0] nq_s3, d_s3;

	// divider chain, entry k holds stage 4+k
	logic           dv_valid_s4 [Steps];
	ialu_pkg::ctx_t dv_ctx_s4   [Steps];
	logic [63:0]    dv_rem_s4   [Steps];
	logic [63:0]    dv_nq_s4    [Steps];
	logic [63:0]    dv_d_s4     [Steps];

	logic [63:0] fin_value;
	logic        fin_bool;
	logic [2:0]  fin_err;

	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic        out_bool_q;
	logic [2:0]  out_err_q;

	// Advance the whole pipe when the output slot frees up.
	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg.valid) begin
			mode_q <= cfg.runtime_mode;
		end
	end

	// Control: valid bits of the front stages and output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= req.valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= dv_valid_s4[Steps-1];
		end
	end

	// Fold the cross partial products into the upper half of a product.
	always_comb begin
		ctx_m = ctx_s2;
		if (ctx_s2.is_mul) begin
			ctx_m.res = pp_ll_s2 + {pp_lh_s2 + pp_hl_s2, 32'd0};
		end
	end

	// Payload of the front stages and output.
	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1 <= req.action;
			type_s1   <= req.type_sel;
			opa_s1    <= req.operand_a;
			opb_s1    <= req.operand_b;
			mode_s1   <= mode_q;

			ctx_s2   <= ctx_x;
			pp_ll_s2 <= pp_ll_x;
			pp_lh_s2 <= pp_lh_x;
			pp_hl_s2 <= pp_hl_x;
			dn_s2    <= dn_x;
			dd_s2    <= dd_x;

			ctx_s3 <= ctx_m;
			nq_s3  <= dn_s2;
			d_s3   <= dd_s2;

			out_value_q <= fin_value;
			out_bool_q  <= fin_bool;
			out_err_q   <= fin_err;
		end
	end

	ialu_exec u_exec (
		.action       (action_s1),
		.type_sel     (type_s1),
		.operand_a    (opa_s1),
		.operand_b    (opb_s1),
		.runtime_mode (mode_s1),
		.ctx          (ctx_x),
		.pp_ll        (pp_ll_x),
		.pp_lh        (pp_lh_x),
		.pp_hl        (pp_hl_x),
		.div_n        (dn_x),
		.div_d        (dd_x)
	);

	// Divider: one quotient bit per stage, MSB first.
	for (genvar k = 0; k < Steps; k++) begin : g_div
		logic [63:0] rem_in, nq_in, d_in, rem_nx, nq_nx;
		logic        valid_in;
		ialu_pkg::ctx_t ctx_in;

		if (k == 0) begin : g_first
			assign rem_in   = 64'd0;
			assign nq_in    = nq_s3;
			assign d_in     = d_s3;
			assign valid_in = valid_s3;
			assign ctx_in   = ctx_s3;
		end else begin : g_next
			assign rem_in   = dv_rem_s4[k-1];
			assign nq_in    = dv_nq_s4[k-1];
			assign d_in     = dv_d_s4[k-1];
			assign valid_in = dv_valid_s4[k-1];
			assign ctx_in   = dv_ctx_s4[k-1];
		end

		ialu_div_step u_step (
			.rem    (rem_in),
			.nq     (nq_in),
			.d      (d_in),
			.rem_nx (rem_nx),
			.nq_nx  (nq_nx)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s4[k] <= 1'b0;
			end else if (adv) begin
				dv_valid_s4[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s4[k] <= rem_nx;
				dv_nq_s4[k]  <= nq_nx;
				dv_d_s4[k]   <= d_in;
				dv_ctx_s4[k] <= ctx_in;
			end
		end
	end

	ialu_finish u_finish (
		.ctx          (dv_ctx_s4[Steps-1]),
		.quo          (dv_nq_s4[Steps-1]),
		.rem          (dv_rem_s4[Steps-1]),
		.result_value (fin_value),
		.is_boolean   (fin_bool),
		.error_code   (fin_err)
	);

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.is_boolean   = out_bool_q;
	assign rsp.error_code   = out_err_q;

`ifndef NO_ASSERTIONS
	// An error beat carries a cleared, non-boolean result.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q != ialu_pkg::ERR_NONE |-> out_value_q == 64'd0 && !out_bool_q)
		else $error("error beat with nonzero result");

	// A compare result is 0 or 1 and never flagged.
	a_bool_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_bool_q |-> out_value_q[63:1] == 63'd0 && out_err_q == ialu_pkg::ERR_NONE)
		else $error("boolean result out of range");

	// A held output beat keeps the stages frozen, checked on the first and last valid bits.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> $stable(valid_s1) && $stable(dv_valid_s4[Steps-1]))
		else $error("pipeline moved during stall");
`endif

endmodule

// ----- rtl/core/ialu_exec.sv -----
// ----------------------------------------------------------------------------
// ialu_exec: operand fitting and combinational operations
// Add, sub, logic, shifts, compares, error checks, multiply partial
// products and divider operand magnitudes.
// ----------------------------------------------------------------------------
module ialu_exec (
	input  logic [3:0]     action,
	input  logic [1:0]     type_sel,
	input  logic [63:0]    operand_a,
	input  logic [63:0]    operand_b,
	input  logic           runtime_mode,
	output ialu_pkg::ctx_t ctx,
	output logic [63:0]    pp_ll,
	output logic [31:0]    pp_lh,
	output logic [31:0]    pp_hl,
	output logic [63:0]    div_n,
	output logic [63:0]    div_d
);

	logic [1:0]  tt;
	logic [63:0] a, b, s, shifted;
	logic [5:0]  sh;
	logic        oor, ovf, min_a, lt, eq, v;

	always_comb begin
		tt = type_sel[1] ? ialu_pkg::TY_ABS : type_sel;
		a  = ialu_pkg::fit_type(operand_a, tt);
		b  = ialu_pkg::fit_type(operand_b, tt);
		s  = operand_b;

		pp_ll = 64'(a[31:0]) * 64'(b[31:0]);
		pp_lh = a[31:0] * b[63:32];
		pp_hl = a[63:32] * b[31:0];
		div_n = (tt != ialu_pkg::TY_U32 && a[63]) ? -a : a;
		div_d = (tt != ialu_pkg::TY_U32 && b[63]) ? -b : b;

		min_a = (tt == ialu_pkg::TY_I32) ? (a == ialu_pkg::I32_MIN_SX)
			: (tt == ialu_pkg::TY_ABS && a == ialu_pkg::I64_MIN);
		lt = (tt == ialu_pkg::TY_U32) ? (a < b) : ($signed(a) < $signed(b));
		eq = (a == b);
		oor = 1'b0;
		ovf = 1'b0;
		sh = 6'd0;
		shifted = 64'd0;
		v = 1'b0;

		ctx = '0;
		ctx.tt = tt;
		ctx.err = ialu_pkg::ERR_NONE;
		ctx.quot = (action == ialu_pkg::OP_DIV);
		ctx.q_neg = (tt != ialu_pkg::TY_U32) && (a[63] ^ b[63]);
		ctx.r_neg = (tt != ialu_pkg::TY_U32) && a[63];

		case (action)
			ialu_pkg::OP_ADD: ctx.res = a + b;
			ialu_pkg::OP_SUB: ctx.res = a - b;
			ialu_pkg::OP_MUL: ctx.is_mul = 1'b1;
			ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
				if (b == 64'd0) begin
					if (!runtime_mode) ctx.err = ialu_pkg::ERR_DIV_ZERO;
					else ctx.res = ctx.quot ? a : 64'd0;
				end else if (tt != ialu_pkg::TY_U32 && min_a && b == '1) begin
					if (!runtime_mode) ctx.err = ialu_pkg::ERR_DIV_OVF;
					else ctx.res = ctx.quot ? a : 64'd0;
				end else begin
					ctx.div_use = 1'b1;
				end
			end
			ialu_pkg::OP_AND: ctx.res = a & b;
			ialu_pkg::OP_OR:  ctx.res = a | b;
			ialu_pkg::OP_XOR: ctx.res = a ^ b;
			ialu_pkg::OP_SHL: begin
				if (tt == ialu_pkg::TY_ABS) begin
					oor = s[63] || (|s[62:6]);
					sh  = s[5:0];
				end else begin
					oor = s[63] || (|s[62:5]);
					sh  = {1'b0, s[4:0]};
				end
				shifted = a << sh;
				case (tt)
					ialu_pkg::TY_U32: ovf = |shifted[63:32];
					ialu_pkg::TY_I32: ovf = shifted[63:32] != {32{shifted[31]}};
					default:          ovf = ($signed(shifted) >>> sh) != $signed(a);
				endcase
				if (oor && !runtime_mode) ctx.err = ialu_pkg::ERR_SHAMT;
				else if (ovf && !runtime_mode) ctx.err = ialu_pkg::ERR_SHL_OVF;
				else ctx.res = shifted;
			end
			ialu_pkg::OP_SHR: begin
				if (tt == ialu_pkg::TY_ABS) begin
					sh = (|s[62:6]) ? 6'd63 : s[5:0];
					if (s[63]) ctx.err = ialu_pkg::ERR_SHAMT;
					else ctx.res = $signed(a) >>> sh;
				end else begin
					oor = s[63] || (|s[62:5]);
					sh  = {1'b0, s[4:0]};
					if (oor && !runtime_mode) ctx.err = ialu_pkg::ERR_SHAMT;
					else if (tt == ialu_pkg::TY_U32) ctx.res = a >> sh;
					else ctx.res = $signed(a) >>> sh;
				end
			end
			default: begin
				case (action)
					ialu_pkg::OP_EQ: v = eq;
					ialu_pkg::OP_NE: v = !eq;
					ialu_pkg::OP_LT: v = lt;
					ialu_pkg::OP_LE: v = lt || eq;
					ialu_pkg::OP_GT: v = !lt && !eq;
					default:         v = !lt;
				endcase
				ctx.is_bool = 1'b1;
				ctx.res = {63'd0, v};
			end
		endcase
	end

endmodule

// ----- rtl/core/ialu_div_step.sv -----
// ----------------------------------------------------------------------------
// ialu_div_step: one restoring division step
// Shift in one dividend bit, trial subtract, produce one quotient bit.
// ----------------------------------------------------------------------------
module ialu_div_step (
	input  logic [63:0] rem,
	input  logic [63:0] nq,
	input  logic [63:0] d,
	output logic [63:0] rem_nx,
	output logic [63:0] nq_nx
);

	logic [64:0] trial, diff;

	always_comb begin
		trial = {rem, nq[63]};
		diff  = trial - {1'b0, d};
		if (!diff[64]) begin
			rem_nx = diff[63:0];
			nq_nx  = {nq[62:0], 1'b1};
		end else begin
			rem_nx = trial[63:0];
			nq_nx  = {nq[62:0], 1'b0};
		end
	end

endmodule

// ----- rtl/core/ialu_finish.sv -----
// ----------------------------------------------------------------------------
// ialu_finish: result selection
// Apply quotient and remainder signs, fit to type, force error results.
// ----------------------------------------------------------------------------
module ialu_finish (
	input  ialu_pkg::ctx_t ctx,
	input  logic [63:0]    quo,
	input  logic [63:0]    rem,
	output logic [63:0]    result_value,
	output logic           is_boolean,
	output logic [2:0]     error_code
);

	logic [63:0] v;

	always_comb begin
		v = ctx.res;
		if (ctx.div_use) begin
			if (ctx.quot) v = ctx.q_neg ? -quo : quo;
			else v = ctx.r_neg ? -rem : rem;
		end
		error_code = ctx.err;
		if (ctx.err != ialu_pkg::ERR_NONE) begin
			result_value = 64'd0;
			is_boolean   = 1'b0;
		end else begin
			is_boolean   = ctx.is_bool;
			result_value = ctx.is_bool ? v : ialu_pkg::fit_type(v, ctx.tt);
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for shader_integer_alu
// Drives typed ALU beats under several idle and stall patterns, predicts each
// result for the mode in force, runs both mode settings and compares results in order, field by field.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic [63:0] value;
		logic        boolean;
		logic [2:0]  err;
	} alu_result_t;

	localparam int unsigned PIPE_DEPTH = 70;
	localparam int unsigned LONG_HOLD = 300;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	ialu_req_if req ();
	ialu_rsp_if rsp ();
	ialu_cfg_if cfg ();

	shader_integer_alu u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// Expected results in issue order, and the mode the predictor works in.
	alu_result_t expected_results[$];
	logic        mode_runtime;
	int          error_count;
	longint unsigned cycle_count;

	// Sender idles with a chance of send_idle_pct percent; receiver stalls with a chance of
	// sink_stall_pct percent. Bumping hold_req asks for a long stall.
	int unsigned send_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned hold_req;
	int unsigned hold_seen;
	int unsigned sink_hold;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] sx32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [63:0] narrow(input logic [63:0] v, input logic [1:0] t);
		if (t == ialu_pkg::TY_I32) return sx32(v);
		if (t == ialu_pkg::TY_U32) return {32'd0, v[31:0]};
		return v;
	endfunction

	// Predict one ALU beat for the current mode.
	function automatic alu_result_t alu_predict(input logic [3:0] op, input logic [1:0] ts,
			input logic [63:0] ra, input logic [63:0] rb, input logic rt);
		alu_result_t res;
		logic [1:0]  t;
		logic [63:0] a, b, r, s, width, sh;
		logic signed [63:0] sa, sb;
		logic [2:0]  err;
		logic        is_b, lt, eq, v, min_a;
		t = (ts == 2'd3) ? ialu_pkg::TY_ABS : ts;
		a = narrow(ra, t);
		b = narrow(rb, t);
		sa = a;
		sb = b;
		r = '0;
		err = ialu_pkg::ERR_NONE;
		is_b = 1'b0;
		case (op)
			ialu_pkg::OP_ADD: r = a + b;
			ialu_pkg::OP_SUB: r = a - b;
			ialu_pkg::OP_MUL: r = a * b;
			ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
				min_a = (t == ialu_pkg::TY_I32) ? (a == ialu_pkg::I32_MIN_SX)
					: (t == ialu_pkg::TY_ABS && a == ialu_pkg::I64_MIN);
				if (b == 0) begin
					if (!rt) err = ialu_pkg::ERR_DIV_ZERO;
					else r = (op == ialu_pkg::OP_DIV) ? a : 64'd0;
				end else if (t != ialu_pkg::TY_U32 && min_a && sb == -1) begin
					if (!rt) err = ialu_pkg::ERR_DIV_OVF;
					else r = (op == ialu_pkg::OP_DIV) ? a : 64'd0;
				end else if (t == ialu_pkg::TY_U32) begin
					r = (op == ialu_pkg::OP_DIV) ? a / b : a % b;
				end else begin
					r = (op == ialu_pkg::OP_DIV) ? sa / sb : sa % sb;
				end
			end
			ialu_pkg::OP_AND: r = a & b;
			ialu_pkg::OP_OR:  r = a | b;
			ialu_pkg::OP_XOR: r = a ^ b;
			ialu_pkg::OP_SHL: begin
				width = (t == ialu_pkg::TY_ABS) ? 64'd64 : 64'd32;
				s = rb;
				if (s[63] || s >= width) begin
					if (!rt) err = ialu_pkg::ERR_SHAMT;
					s = s & (width - 1);
				end
				if (err == ialu_pkg::ERR_NONE) begin
					sh = a << s;
					if (t == ialu_pkg::TY_U32) begin
						if (sh > 64'hFFFF_FFFF && !rt) err = ialu_pkg::ERR_SHL_OVF;
						r = {32'd0, sh[31:0]};
					end else if (t == ialu_pkg::TY_I32) begin
						if (sx32(sh) != sh && !rt) err = ialu_pkg::ERR_SHL_OVF;
						r = sx32(sh);
					end else begin
						if (($signed(sh) >>> s) != $signed(a) && !rt)
							err = ialu_pkg::ERR_SHL_OVF;
						r = sh;
					end
				end
			end
			ialu_pkg::OP_SHR: begin
				s = rb;
				if (t == ialu_pkg::TY_ABS) begin
					if (s[63]) err = ialu_pkg::ERR_SHAMT;
					else if (s >= 63) r = {64{a[63]}};
					else r = $signed(a) >>> s;
				end else begin
					if (s[63] || s >= 32) begin
						if (!rt) err = ialu_pkg::ERR_SHAMT;
						s = s & 64'd31;
					end
					if (t == ialu_pkg::TY_U32) r = {32'd0, a[31:0]} >> s;
					else r = $signed(a) >>> s;
				end
			end
			default: begin
				lt = (t == ialu_pkg::TY_U32) ? (a < b) : (sa < sb);
				eq = (a == b);
				is_b = 1'b1;
				case (op)
					ialu_pkg::OP_EQ: v = eq;
					ialu_pkg::OP_NE: v = !eq;
					ialu_pkg::OP_LT: v = lt;
					ialu_pkg::OP_LE: v = lt || eq;
					ialu_pkg::OP_GT: v = !lt && !eq;
					default:         v = !lt;
				endcase
				r = {63'd0, v};
			end
		endcase
		if (err != ialu_pkg::ERR_NONE) begin
			r = '0;
			is_b = 1'b0;
		end else if (!is_b) begin
			r = narrow(r, t);
		end
		res.value = r;
		res.boolean = is_b;
		res.err = err;
		return res;
	endfunction

	// Offer one beat, holding it until accepted; record its expectation.
	task automatic send_op(input logic [3:0] op, input logic [1:0] ts,
			input logic [63:0] a, input logic [63:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.action    <= op;
		req.type_sel  <= ts;
		req.operand_a <= a;
		req.operand_b <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		expected_results.push_back(alu_predict(op, ts, a, b, mode_runtime));
	endtask

	task automatic go_idle();
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain the pipeline, then write the mode register.
	task automatic set_mode(input logic m);
		req.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
		cfg.valid        <= 1'b1;
		cfg.runtime_mode <= m;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		mode_runtime = m;
	endtask

	// Operand picks biased toward boundary values.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return 64'hFFFF_FFFF_FFFF_FFFF;
			2: return ialu_pkg::I64_MIN;
			3: return 64'h7FFF_FFFF_FFFF_FFFF;
			4: return ialu_pkg::I32_MIN_SX;
			5: return 64'd0 + $urandom_range(70);
			6: return -(64'd0 + $urandom_range(70));
			7: return {32'd0, $urandom()};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic random_ops(input int n);
		logic [63:0] b;
		for (int i = 0; i < n; i++) begin
			b = pick_operand();
			send_op(4'($urandom_range(15)), 2'($urandom_range(3)), pick_operand(), b);
		end
		go_idle();
	endtask

	// Boundary beats: every operation, each overflow, shift and zero-divisor case.
	task automatic test_directed();
		for (int op = 0; op < 16; op++)
			send_op(4'(op), 2'(op % 3), 64'hFFFF_FFFF_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
		send_op(ialu_pkg::OP_DIV, ialu_pkg::TY_I32, ialu_pkg::I32_MIN_SX, -64'sd1);
		send_op(ialu_pkg::OP_REM, ialu_pkg::TY_ABS, ialu_pkg::I64_MIN, -64'sd1);
		send_op(ialu_pkg::OP_DIV, ialu_pkg::TY_U32, 64'd7, 64'h1_0000_0000);
		send_op(ialu_pkg::OP_REM, ialu_pkg::TY_I32, -64'sd7, 64'd0);
		send_op(ialu_pkg::OP_SHL, ialu_pkg::TY_U32, 64'h8000_0001, 64'd1);
		send_op(ialu_pkg::OP_SHL, ialu_pkg::TY_I32, 64'd1, 64'd32);
		send_op(ialu_pkg::OP_SHL, ialu_pkg::TY_ABS, 64'd3, 64'd63);
		send_op(ialu_pkg::OP_SHR, ialu_pkg::TY_ABS, ialu_pkg::I64_MIN, 64'd70);
		send_op(ialu_pkg::OP_SHR, ialu_pkg::TY_ABS, 64'd5, -64'sd1);
		send_op(ialu_pkg::OP_SHR, ialu_pkg::TY_I32, ialu_pkg::I32_MIN_SX, -64'sd1);
		send_op(ialu_pkg::OP_LT, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		go_idle();
	endtask

	// Long receiver hold while the sender keeps offering beats.
	task automatic test_backpressure();
		hold_req = hold_req + 1;
		random_ops(150);
	endtask

	initial begin
		int unsigned phase_idle[4] = '{0, 55, 0, 7};
		int unsigned phase_stall[4] = '{0, 0, 55, 7};
		error_count   = 0;
		mode_runtime  = 1'b0;
		send_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req      = 0;
		arst_n        = 1'b0;
		req.valid     <= 1'b0;
		req.action    <= ialu_pkg::OP_ADD;
		req.type_sel  <= ialu_pkg::TY_I32;
		req.operand_a <= '0;
		req.operand_b <= '0;
		cfg.valid     <= 1'b0;
		cfg.runtime_mode <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(1'b0);
		test_directed();
		set_mode(1'b1);
		test_directed();
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = phase_idle[p];
			sink_stall_pct = phase_stall[p];
			set_mode(p[0]);
			random_ops(170);
			set_mode(!p[0]);
			random_ops(170);
		end
		send_idle_pct  = 0;
		sink_stall_pct = 10;
		test_backpressure();

		while (expected_results.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Drive receiver ready; a new hold request drops ready for a long hold set by LONG_HOLD.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			sink_hold <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			rsp.ready <= 1'b0;
			sink_hold <= LONG_HOLD;
			hold_seen <= hold_req;
		end else if (sink_hold != 0) begin
			rsp.ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compare every accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		alu_result_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result beat: value %h", rsp.result_value);
			end else begin
				exp_r = expected_results.pop_front();
				if (rsp.result_value !== exp_r.value || rsp.is_boolean !== exp_r.boolean
						|| rsp.error_code !== exp_r.err) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: exp %h/%b/%0d got %h/%b/%0d",
							exp_r.value, exp_r.boolean, exp_r.err,
							rsp.result_value, rsp.is_boolean, rsp.error_code);
				end
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule
